// ===== hdl/mpp_pkg.sv =====
// mpp_pkg: shared constants and types for the map point projection block
// register indexes, reset values, default widths; no dependencies
`timescale 1ns / 1ps

package mpp_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 14;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 32;
	localparam int DEPTH_W        = 24;
	// quotient bits kept; anything at or above 2^QBITS saturates the result
	localparam int QBITS          = 17;
	localparam int FRONT_LAT      = 5;
	localparam int LANE_LAT       = QBITS + 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROTATION    = 3'd0,
		CFG_TILT        = 3'd1,
		CFG_MAP_CENTER  = 3'd2,
		CFG_HGT_CENTER  = 3'd3,
		CFG_SCALE       = 3'd4,
		CFG_OFFSET      = 3'd5,
		CFG_CAM_DIST    = 3'd6,
		CFG_PERSPECTIVE = 3'd7
	} cfg_idx_t;

	localparam logic [31:0]        ROTATION_RST = 32'h4000_0000;
	localparam logic [31:0]        TILT_RST     = 32'h4000_0000;
	localparam logic [31:0]        SCALE_RST    = 32'h0001_0000;
	localparam logic [DEPTH_W-1:0] CAM_DIST_RST = 24'h00_0100;
	localparam logic [DEPTH_W-1:0] DEPTH_ONE    = 24'h00_0100;

endpackage

// ===== hdl/map_point_projection.sv =====
// map_point_projection: height-map point to screen coordinate transform
// front end: recenter, rotate, tilt; two mpp_lane instances; uses mpp_pkg
//
// channel   dir  word
// s_axis    in   column, row, height
// m_axis    out  screen_x, screen_y
// cfg       in   register index, write data
//
// one word per cycle sustained while m_axis does not stall; the pipeline length
// FRONT_LAT + LANE_LAT is set mostly by the 17-stage restoring divider in each lane
// arst_n clears the valid bits and the registers to their reset values
// a stall at m_axis freezes the whole pipeline; s_tready drops with it
`timescale 1ns / 1ps

module map_point_projection #(
	parameter int COORD_BITS = mpp_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = mpp_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// column, row, height, zero fill
	input  logic [((2*COORD_BITS+16+7)/8)*8-1:0]   s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// screen_x, screen_y
	output logic [31:0]                            m_tdata,
	input  logic                                   cfg_wen,
	input  logic [mpp_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [mpp_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

	localparam int CW  = COORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int DW  = ((CW + 1 > 16) ? CW + 1 : 16) + 1;
	localparam int MW  = DW + 16;
	localparam int FW  = MW + 1;
	localparam int ZW  = 17;
	localparam int TW  = ((FW + 16 > ZW + 16 + F + 1) ? FW + 16 : ZW + 16 + F + 1) + 1;
	localparam int N   = mpp_pkg::FRONT_LAT + mpp_pkg::LANE_LAT;
	localparam int DPW = mpp_pkg::DEPTH_W;

	logic [31:0]     rot_q, tilt_q, mc_q, scale_q, off_q;
	logic [15:0]     hc_q;
	logic [DPW-1:0]  cam_q;
	logic            persp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q   <= mpp_pkg::ROTATION_RST;
			tilt_q  <= mpp_pkg::TILT_RST;
			mc_q    <= '0;
			hc_q    <= '0;
			scale_q <= mpp_pkg::SCALE_RST;
			off_q   <= '0;
			cam_q   <= mpp_pkg::CAM_DIST_RST;
			persp_q <= 1'b0;
		end else if (cfg_wen) begin
			unique case (mpp_pkg::cfg_idx_t'(cfg_index))
				mpp_pkg::CFG_ROTATION:    rot_q   <= cfg_wdata;
				mpp_pkg::CFG_TILT:        tilt_q  <= cfg_wdata;
				mpp_pkg::CFG_MAP_CENTER:  mc_q    <= cfg_wdata;
				mpp_pkg::CFG_HGT_CENTER:  hc_q    <= cfg_wdata[15:0];
				mpp_pkg::CFG_SCALE:       scale_q <= cfg_wdata;
				mpp_pkg::CFG_OFFSET:      off_q   <= cfg_wdata;
				mpp_pkg::CFG_CAM_DIST:    cam_q   <= cfg_wdata[DPW-1:0];
				mpp_pkg::CFG_PERSPECTIVE: persp_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	logic en;
	logic vld_s [N];

	assign en       = !vld_s[N-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++)
				vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= s_tvalid;
			for (int i = 1; i < N; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	logic [CW-1:0]      col, row;
	logic signed [15:0] hgt;
	logic signed [15:0] rc, rs, tc, ts;
	logic signed [25:0] dep;
	logic [DPW-1:0]     d_in;

	assign col = s_tdata[CW-1:0];
	assign row = s_tdata[2*CW-1:CW];
	assign hgt = signed'(s_tdata[2*CW+15:2*CW]);
	assign rc  = signed'(rot_q[31:16]);
	assign rs  = signed'(rot_q[15:0]);
	assign tc  = signed'(tilt_q[31:16]);
	assign ts  = signed'(tilt_q[15:0]);
	assign dep = signed'({2'b00, cam_q}) - signed'(26'(row) << 8);

	always_comb begin
		if (!persp_q)
			d_in = DPW'(1);
		else if (dep < signed'(26'(mpp_pkg::DEPTH_ONE)))
			d_in = mpp_pkg::DEPTH_ONE;
		else
			d_in = dep[DPW-1:0];
	end

	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [ZW-1:0] zc_s1, zc_s2, zc_s3;
	logic [DPW-1:0]       d_s1, d_s2, d_s3, d_s4, d_s5;
	logic signed [MW-1:0] xc_s2, ys_s2, xs_s2, yc_s2;
	logic signed [FW-1:0] fx_s3, fy_s3, fx_s4, fx_s5;
	logic signed [FW+15:0] fyt_s4;
	logic signed [ZW+15:0] zts_s4;
	logic signed [TW-1:0] ty_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= signed'(DW'({col, 1'b0})) - signed'(DW'(mc_q[31:16]));
			dy_s1 <= signed'(DW'({row, 1'b0})) - signed'(DW'(mc_q[15:0]));
			zc_s1 <= ZW'(hgt) - ZW'(signed'(hc_q));
			d_s1  <= d_in;

			xc_s2 <= dx_s1 * rc;
			ys_s2 <= dy_s1 * rs;
			xs_s2 <= dx_s1 * rs;
			yc_s2 <= dy_s1 * rc;
			zc_s2 <= zc_s1;
			d_s2  <= d_s1;

			fx_s3 <= FW'(xc_s2) - FW'(ys_s2);
			fy_s3 <= FW'(xs_s2) + FW'(yc_s2);
			zc_s3 <= zc_s2;
			d_s3  <= d_s2;

			fyt_s4 <= fy_s3 * tc;
			zts_s4 <= zc_s3 * ts;
			fx_s4  <= fx_s3;
			d_s4   <= d_s3;

			ty_s5 <= TW'(fyt_s4) - (TW'(zts_s4) <<< (F + 1));
			fx_s5 <= fx_s4;
			d_s5  <= d_s4;
		end
	end

	logic signed [15:0] sx, sy;

	mpp_lane #(
		.AW   (FW),
		.SH_O (F + 17),
		.SH_P (F + 9)
	) u_lane_x (
		.clk   (clk),
		.en    (en),
		.persp (persp_q),
		.scale (scale_q),
		.off   (signed'(off_q[31:16])),
		.a     (fx_s5),
		.d     (d_s5),
		.res   (sx)
	);

	mpp_lane #(
		.AW   (TW),
		.SH_O (2 * F + 17),
		.SH_P (2 * F + 9)
	) u_lane_y (
		.clk   (clk),
		.en    (en),
		.persp (persp_q),
		.scale (scale_q),
		.off   (signed'(off_q[15:0])),
		.a     (ty_s5),
		.d     (d_s5),
		.res   (sy)
	);

	assign m_tdata = {sy, sx};

endmodule

// ===== hdl/mpp_lane.sv =====
// mpp_lane: scale, shift, divide by depth, offset and saturate for one axis
// pipelined magnitude multiply and restoring divider; uses mpp_pkg
`timescale 1ns / 1ps

module mpp_lane #(
	parameter int AW   = 35,
	parameter int SH_O = 31,
	parameter int SH_P = 23
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic                            persp,
	input  logic [31:0]                     scale,
	input  logic signed [15:0]              off,
	input  logic signed [AW-1:0]            a,
	input  logic [mpp_pkg::DEPTH_W-1:0]     d,
	output logic signed [15:0]              res
);

	localparam int HW = (AW + 1) / 2;
	localparam int PW = AW + 32;
	localparam int VW = PW - SH_P;
	localparam int QB = mpp_pkg::QBITS;
	localparam int DW = mpp_pkg::DEPTH_W;
	localparam int RW = DW + 1;
	localparam int NW = QB + 3;
	localparam logic signed [NW-1:0] SMAX = NW'(32767);
	localparam logic signed [NW-1:0] SMIN = -NW'(32768);

	logic          neg_s1;
	logic [AW-1:0] mag_s1;
	logic [DW-1:0] d_s1;

	logic                 neg_s2;
	logic [HW+31:0]       pl_s2;
	logic [AW-HW+31:0]    ph_s2;
	logic [DW-1:0]        d_s2;

	logic          neg_s3;
	logic [PW-1:0] prod_s3;
	logic [DW-1:0] d_s3;

	logic          neg_s4;
	logic          frac_s4;
	logic [VW-1:0] v_s4;
	logic [DW-1:0] d_s4;

	logic [RW-1:0] rem_s  [QB+1];
	logic [QB-1:0] low_s  [QB+1];
	logic [QB-1:0] quo_s  [QB+1];
	logic [DW-1:0] dd_s   [QB+1];
	logic          neg_s  [QB+1];
	logic          frac_s [QB+1];
	logic          ovf_s  [QB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[AW-1];
			mag_s1 <= a[AW-1] ? AW'(-a) : AW'(a);
			d_s1   <= d;

			neg_s2 <= neg_s1;
			pl_s2  <= mag_s1[HW-1:0] * scale;
			ph_s2  <= mag_s1[AW-1:HW] * scale;
			d_s2   <= d_s1;

			neg_s3  <= neg_s2;
			prod_s3 <= PW'(pl_s2) + (PW'(ph_s2) << HW);
			d_s3    <= d_s2;

			neg_s4  <= neg_s3;
			v_s4    <= persp ? VW'(prod_s3 >> SH_P) : VW'(prod_s3 >> SH_O);
			frac_s4 <= persp ? (prod_s3[SH_P-1:0] != '0) : (prod_s3[SH_O-1:0] != '0);
			d_s4    <= d_s3;

			rem_s[0]  <= RW'(v_s4 >> QB);
			low_s[0]  <= v_s4[QB-1:0];
			quo_s[0]  <= '0;
			dd_s[0]   <= d_s4;
			neg_s[0]  <= neg_s4;
			frac_s[0] <= frac_s4;
			ovf_s[0]  <= (v_s4 >> QB) >= VW'(d_s4);
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [RW-1:0] trial;
		logic          take;
		assign trial = {rem_s[k][RW-2:0], low_s[k][QB-1]};
		assign take  = trial >= {1'b0, dd_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? trial - {1'b0, dd_s[k]} : trial;
				low_s[k+1]  <= low_s[k] << 1;
				quo_s[k+1]  <= {quo_s[k][QB-2:0], take};
				dd_s[k+1]   <= dd_s[k];
				neg_s[k+1]  <= neg_s[k];
				frac_s[k+1] <= frac_s[k];
				ovf_s[k+1]  <= ovf_s[k];
			end
		end
	end

	logic              frac_f;
	logic [QB:0]       qx;
	logic signed [NW-1:0] q_e, off_e, n, r;

	always_comb begin
		frac_f = frac_s[QB] | (rem_s[QB] != '0);
		qx     = ovf_s[QB] ? (QB+1)'(1) << QB : {1'b0, quo_s[QB]};
		q_e    = signed'(NW'(qx));
		off_e  = NW'(off);
		if (neg_s[QB]) begin
			n = off_e - q_e;
			r = (n > 0 && frac_f) ? n - 1 : n;
		end else begin
			n = q_e + off_e;
			r = (n < 0 && frac_f) ? n + 1 : n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (r > SMAX)
				res <= 16'sh7fff;
			else if (r < SMIN)
				res <= -16'sh8000;
			else
				res <= r[15:0];
		end
	end

endmodule

// ===== tb/mpp_checker.sv =====
// mpp_checker: watches the point, screen and register ports of map_point_projection
// keeps its own copy of the registers, predicts each screen word and compares; uses mpp_pkg
`timescale 1ns / 1ps

module mpp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	output int          pending,
	output int          errors
);

	localparam int FB = mpp_pkg::FRAC_BITS_DEF;

	logic [31:0] rot_r, tilt_r, center_r, scale_r, offset_r;
	logic [15:0] hctr_r;
	logic [23:0] cam_r;
	logic        persp_r;
	logic [31:0] screen_q[$];

	// trunc(a * s / (2^sh * d) + off), saturated to 16 bits
	function automatic logic [15:0] scale_trunc(longint a, logic [31:0] s, int sh,
			longint unsigned d, longint off);
		logic         neg;
		logic [127:0] mag, prod, v, q;
		logic         frac;
		longint       n, r;
		neg  = a < 0;
		mag  = neg ? 128'(-a) : 128'(a);
		prod = mag * 128'(s);
		v    = prod >> sh;
		frac = (prod & ((128'd1 << sh) - 1)) != 0;
		q    = v / 128'(d);
		if (v % 128'(d) != 0)
			frac = 1'b1;
		if (q > (128'd1 << 40))
			q = 128'd1 << 40;
		if (!neg) begin
			n = longint'(q) + off;
			r = (n < 0 && frac) ? n + 1 : n;
		end else begin
			n = off - longint'(q);
			r = (n > 0 && frac) ? n - 1 : n;
		end
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	// depth below one is held at one
	function automatic longint unsigned n_depth(longint row);
		longint dep;
		dep = longint'(cam_r) - row * 256;
		if (dep < 256)
			dep = 256;
		return longint'(dep);
	endfunction

	function automatic logic [31:0] project_point(logic [39:0] w);
		longint col, row, hgt, rc, rs, tc, ts, dx, dy, fx, fy, zc, ty;
		longint unsigned depth;
		int shx, shy;
		col   = longint'(w[11:0]);
		row   = longint'(w[23:12]);
		hgt   = longint'($signed(w[39:24]));
		rc    = longint'($signed(rot_r[31:16]));
		rs    = longint'($signed(rot_r[15:0]));
		tc    = longint'($signed(tilt_r[31:16]));
		ts    = longint'($signed(tilt_r[15:0]));
		dx    = 2 * col - longint'(center_r[31:16]);
		dy    = 2 * row - longint'(center_r[15:0]);
		fx    = dx * rc - dy * rs;
		fy    = dx * rs + dy * rc;
		zc    = hgt - longint'($signed(hctr_r));
		ty    = fy * tc - zc * ts * (longint'(1) << (FB + 1));
		shx   = FB + 17;
		shy   = 2 * FB + 17;
		depth = 1;
		if (persp_r) begin
			depth = n_depth(row);
			shx -= 8;
			shy -= 8;
		end
		return {scale_trunc(ty, scale_r, shy, depth, longint'($signed(offset_r[15:0]))),
			scale_trunc(fx, scale_r, shx, depth, longint'($signed(offset_r[31:16])))};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			rot_r    <= mpp_pkg::ROTATION_RST;
			tilt_r   <= mpp_pkg::TILT_RST;
			center_r <= '0;
			hctr_r   <= '0;
			scale_r  <= mpp_pkg::SCALE_RST;
			offset_r <= '0;
			cam_r    <= mpp_pkg::CAM_DIST_RST;
			persp_r  <= 1'b0;
			errors   <= 0;
			pending  <= 0;
			screen_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				screen_q.push_back(project_point(s_tdata));
			if (m_tvalid && m_tready) begin
				if (screen_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected screen word %h", m_tdata);
					errors <= errors + 1;
				end else begin
					want = screen_q.pop_front();
					if (want !== m_tdata) begin
						if (errors < 10)
							$display("screen mismatch: x exp %0d got %0d, y exp %0d got %0d",
								$signed(want[15:0]), $signed(m_tdata[15:0]),
								$signed(want[31:16]), $signed(m_tdata[31:16]));
						errors <= errors + 1;
					end
				end
			end
			pending <= screen_q.size();
			if (cfg_wen) begin
				case (mpp_pkg::cfg_idx_t'(cfg_index))
					mpp_pkg::CFG_ROTATION:    rot_r    <= cfg_wdata;
					mpp_pkg::CFG_TILT:        tilt_r   <= cfg_wdata;
					mpp_pkg::CFG_MAP_CENTER:  center_r <= cfg_wdata;
					mpp_pkg::CFG_HGT_CENTER:  hctr_r   <= cfg_wdata[15:0];
					mpp_pkg::CFG_SCALE:       scale_r  <= cfg_wdata;
					mpp_pkg::CFG_OFFSET:      offset_r <= cfg_wdata;
					mpp_pkg::CFG_CAM_DIST:    cam_r    <= cfg_wdata[23:0];
					mpp_pkg::CFG_PERSPECTIVE: persp_r  <= cfg_wdata[0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== tb/tb_map_point_projection.sv =====
// tb_map_point_projection: stimulus and verdict for map_point_projection
// drives register settings and points with random gaps and stalls; uses mpp_checker, mpp_pkg
`timescale 1ns / 1ps

module tb_map_point_projection;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// column, row, height
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// screen_x, screen_y
	logic [31:0] m_tdata;
	logic        cfg_wen = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	int          pending, errors;
	logic        calm = 1'b0;
	int          stall_left = 0;
	int unsigned cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	map_point_projection i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	mpp_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.pending(pending), .errors(errors)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver stalls in bursts
	always @(negedge clk) begin
		if (!arst_n || calm) begin
			m_tready <= arst_n;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_regs(input logic [31:0] rot, tilt, center, hctr, scale, offset,
			cam, persp);
		logic [31:0] vals[8];
		vals = '{rot, tilt, center, hctr, scale, offset, cam, persp};
		settle();
		for (int i = 0; i < 8; i++) begin
			cfg_wen   <= 1'b1;
			cfg_index <= mpp_pkg::cfg_idx_t'(i);
			cfg_wdata <= vals[i];
			@(negedge clk);
		end
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_point(input logic [11:0] col, row, input logic [15:0] hgt);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {hgt, row, col};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	function automatic logic [11:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 12'd0;
			1: return 12'hFFF;
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [15:0] rand_height();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 255)) - 16'd128;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic rand_config();
		logic [31:0] scale;
		case ($urandom_range(0, 3))
			0: scale = $urandom;
			1: scale = $urandom_range(0, 32'h0004_0000);
			default: scale = $urandom_range(0, 32'h0000_4000);
		endcase
		write_regs($urandom, $urandom, $urandom, $urandom, scale, $urandom,
			$urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 6),
			$urandom_range(0, 1));
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// default registers
		send_point(12'd0, 12'd0, 16'd0);
		send_point(12'hFFF, 12'hFFF, 16'h7FFF);
		send_point(12'd0, 12'hFFF, 16'h8000);
		send_point(12'hFFF, 12'd0, 16'hFFFF);
		send_point(12'h800, 12'h7FF, 16'h0001);
		send_point(12'h555, 12'hAAA, 16'h5555);
		send_point(12'hAAA, 12'h555, 16'hAAAA);

		// zero scale, extreme offsets and coefficients
		write_regs(32'h8000_7FFF, 32'h7FFF_8000, 32'hFFFF_FFFF, 32'h0000_8000,
			32'h0, 32'h8000_7FFF, 32'hFFFFFF, 32'h1);
		send_point(12'd0, 12'd0, 16'h7FFF);
		send_point(12'hFFF, 12'hFFF, 16'h8000);
		send_point(12'h123, 12'h456, 16'h0000);

		// huge scale for overflow, orthographic
		write_regs(32'h8000_8000, 32'h8000_7FFF, 32'h0, 32'h0000_7FFF,
			32'hFFFF_FFFF, 32'h7FFF_8000, 32'h0, 32'h0);
		send_point(12'hFFF, 12'hFFF, 16'h8000);
		send_point(12'd0, 12'hFFF, 16'h7FFF);
		send_point(12'd1, 12'd1, 16'h0000);

		// perspective with the camera close, depth held at one
		write_regs(32'h2D41_2D41, 32'h3000_1000, 32'h1000_1000, 32'h0,
			32'h0002_0000, 32'h0100_0080, 32'h000080, 32'h1);
		send_point(12'd0, 12'd0, 16'd100);
		send_point(12'hFFF, 12'hFFF, 16'h8000);
		send_point(12'h800, 12'h001, 16'h7FFF);

		// perspective with the camera far
		write_regs(32'h4000_0000, 32'h3800_0800, 32'h1000_1000, 32'h0000_0200,
			32'h0040_0000, 32'h0, 32'h100800, 32'h1);
		send_point(12'h800, 12'h800, 16'd512);
		send_point(12'h000, 12'hFFF, 16'h0000);
		send_point(12'hFFF, 12'h000, 16'h7FFF);

		for (int ph = 0; ph < 12; ph++) begin
			rand_config();
			if (ph == 11)
				calm = 1'b1;
			for (int k = 0; k < 105; k++)
				send_point(rand_coord(), rand_coord(), rand_height());
		end

		settle();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
